// File: design/iui_pkg.sv
// iui_pkg: shared types and codes for the interval union insert block
// used by the merge unit and the top level; no dependencies
package iui_pkg;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // position of the scan relative to the interval being inserted
    typedef enum logic [1:0] {
        PH_BEFORE,
        PH_MERGE,
        PH_AFTER
    } phase_t;

    typedef enum logic [1:0] {
        CLS_BEFORE,
        CLS_MERGE,
        CLS_AFTER
    } cls_t;

    typedef struct packed {
        cls_t               cls;
        logic signed [31:0] m_start;
        logic signed [31:0] m_end;
    } merge_res_t;

endpackage

// File: design/iui_req_if.sv
// iui_req_if: request channel of the interval union insert block
// valid/ready handshake with operation code, endpoints and read index
interface iui_req_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] bound_a;
    logic signed [31:0] bound_b;
    logic [5:0]         read_index;

    modport source (output valid, func, bound_a, bound_b, read_index, input ready);
    modport sink (input valid, func, bound_a, bound_b, read_index, output ready);
endinterface

// File: design/iui_rsp_if.sv
// iui_rsp_if: result channel of the interval union insert block
// valid/ready handshake with interval, count and status flags
interface iui_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_start;
    logic signed [31:0] result_end;
    logic [6:0]         stored_count;
    logic               entry_valid;
    logic               overflow;

    modport source (output valid, result_start, result_end, stored_count, entry_valid,
                    overflow, input ready);
    modport sink (input valid, result_start, result_end, stored_count, entry_valid,
                  overflow, output ready);
endinterface

// File: design/iui_ram.sv
// iui_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module iui_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/iui_merge_unit.sv
// iui_merge_unit: shared compare unit that classifies one stored entry against
// the interval being inserted and widens the merged bounds; uses iui_pkg
module iui_merge_unit import iui_pkg::*; (
    input  entry_t             ent,
    input  logic signed [31:0] key_a,
    input  logic signed [31:0] key_b,
    input  phase_t             phase,
    input  logic signed [31:0] m_start,
    input  logic signed [31:0] m_end,
    output merge_res_t         res
);

    always_comb
    begin
        priority if (phase == PH_AFTER)
        begin
            res.cls = CLS_AFTER;
        end
        else if (phase == PH_BEFORE && ent.hi < key_a)
        begin
            res.cls = CLS_BEFORE;
        end
        else if (ent.lo <= key_b)
        begin
            res.cls = CLS_MERGE;
        end
        else
        begin
            res.cls = CLS_AFTER;
        end
        res.m_start = (ent.lo < m_start) ? ent.lo : m_start;
        res.m_end   = (ent.hi > m_end) ? ent.hi : m_end;
    end

endmodule

// File: design/interval_union_insert.sv
// interval_union_insert: sorted table of disjoint closed intervals with insert and read
// uses iui_pkg, iui_req_if, iui_rsp_if, iui_ram and iui_merge_unit
//
// channels: req carries func, bound_a, bound_b and read_index; rsp returns
// result_start, result_end, stored_count, entry_valid and overflow. both use
// valid/ready and a request moves on a clock edge with both high.
// one request is worked on at a time; req.ready is high only while idle.
// an insert streams the active table bank once through the merge unit and
// rewrites the merged table into the other bank, which becomes active unless
// the insert is refused; it passes through the scan, flush and done states.
// a read waits in the read state for the registered ram read, then goes to done.
// req.ready returns high in the same cycle as the result becomes valid.
// a refused insert leaves the active bank and the count untouched.
// the result waits in an output register; while the receiver stalls the
// block finishes the request it holds, then waits before going idle.
// reset clears the count and control state; table contents need no clearing
// because entries at or above the count are never read as valid.
module interval_union_insert import iui_pkg::*; #(
    parameter int MAX_INTERVALS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    iui_req_if.sink   req,
    iui_rsp_if.source rsp
);

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic               bank_reg, bank_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [CW-1:0]      wr_idx_reg, wr_idx_next;
    phase_t             phase_reg, phase_next;
    logic signed [31:0] key_a_reg, key_a_next;
    logic signed [31:0] key_b_reg, key_b_next;
    logic signed [31:0] m_start_reg, m_start_next;
    logic signed [31:0] m_end_reg, m_end_next;
    logic               merged_reg, merged_next;
    entry_t             hold_reg, hold_next;
    logic               idx_ok_reg, idx_ok_next;
    logic signed [31:0] res_start_reg, res_start_next;
    logic signed [31:0] res_end_reg, res_end_next;
    logic               res_valid_reg, res_valid_next;
    logic               res_ovf_reg, res_ovf_next;
    logic signed [31:0] out_start_reg, out_start_next;
    logic signed [31:0] out_end_reg, out_end_next;
    logic [6:0]         out_count_reg, out_count_next;
    logic               out_entry_reg, out_entry_next;
    logic               out_ovf_reg, out_ovf_next;
    logic               out_vld_reg, out_vld_next;

    logic               wr_en;
    entry_t             wr_data;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data0;
    logic [ENTRY_W-1:0] rd_data1;
    entry_t             rd_data;
    merge_res_t         mres;
    logic               ovf;
    entry_t             merged_ent;

    // two banks: read from the active one, rebuild into the other
    iui_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_INTERVALS)
    ) u_bank0 (
        .clk   (clk),
        .we    (wr_en & bank_reg),
        .waddr (wr_idx_reg[AW-1:0]),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data0)
    );

    iui_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_INTERVALS)
    ) u_bank1 (
        .clk   (clk),
        .we    (wr_en & ~bank_reg),
        .waddr (wr_idx_reg[AW-1:0]),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data1)
    );

    assign rd_data = bank_reg ? entry_t'(rd_data1) : entry_t'(rd_data0);

    iui_merge_unit u_merge (
        .ent     (rd_data),
        .key_a   (key_a_reg),
        .key_b   (key_b_reg),
        .phase   (phase_reg),
        .m_start (m_start_reg),
        .m_end   (m_end_reg),
        .res     (mres)
    );

    assign merged_ent = '{lo: m_start_reg, hi: m_end_reg};
    assign ovf        = !merged_reg && (count_reg >= CW'(MAX_INTERVALS));

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_vld_reg;
    assign rsp.result_start = out_start_reg;
    assign rsp.result_end   = out_end_reg;
    assign rsp.stored_count = out_count_reg;
    assign rsp.entry_valid  = out_entry_reg;
    assign rsp.overflow     = out_ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        rd_vld_next    = rd_vld_reg;
        wr_idx_next    = wr_idx_reg;
        phase_next     = phase_reg;
        key_a_next     = key_a_reg;
        key_b_next     = key_b_reg;
        m_start_next   = m_start_reg;
        m_end_next     = m_end_reg;
        merged_next    = merged_reg;
        hold_next      = hold_reg;
        idx_ok_next    = idx_ok_reg;
        res_start_next = res_start_reg;
        res_end_next   = res_end_reg;
        res_valid_next = res_valid_reg;
        res_ovf_next   = res_ovf_reg;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_count_next = out_count_reg;
        out_entry_next = out_entry_reg;
        out_ovf_next   = out_ovf_reg;
        out_vld_next   = out_vld_reg;
        wr_en          = 1'b0;
        wr_data        = hold_reg;
        rd_addr        = AW'(req.read_index);

        if (out_vld_reg && rsp.ready)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.func == FUNC_READ)
                    begin
                        idx_ok_next = (32'(req.read_index) < 32'(count_reg));
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        if (req.bound_a > req.bound_b)
                        begin
                            key_a_next   = req.bound_b;
                            key_b_next   = req.bound_a;
                            m_start_next = req.bound_b;
                            m_end_next   = req.bound_a;
                        end
                        else
                        begin
                            key_a_next   = req.bound_a;
                            key_b_next   = req.bound_b;
                            m_start_next = req.bound_a;
                            m_end_next   = req.bound_b;
                        end
                        phase_next  = PH_BEFORE;
                        merged_next = 1'b0;
                        scan_next   = '0;
                        wr_idx_next = '0;
                        rd_vld_next = 1'b0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_READ:
            begin
                res_start_next = idx_ok_reg ? rd_data.lo : 32'sd0;
                res_end_next   = idx_ok_reg ? rd_data.hi : 32'sd0;
                res_valid_next = idx_ok_reg;
                res_ovf_next   = 1'b0;
                state_next     = ST_DONE;
            end
            ST_SCAN:
            begin
                rd_addr = scan_reg[AW-1:0];
                if (scan_reg < count_reg)
                begin
                    scan_next   = scan_reg + CW'(1);
                    rd_vld_next = 1'b1;
                end
                else
                begin
                    rd_vld_next = 1'b0;
                    if (!rd_vld_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
                if (rd_vld_reg)
                begin
                    unique case (mres.cls)
                        CLS_BEFORE:
                        begin
                            wr_en       = 1'b1;
                            wr_data     = rd_data;
                            wr_idx_next = wr_idx_reg + CW'(1);
                        end
                        CLS_MERGE:
                        begin
                            merged_next  = 1'b1;
                            phase_next   = PH_MERGE;
                            m_start_next = mres.m_start;
                            m_end_next   = mres.m_end;
                        end
                        CLS_AFTER:
                        begin
                            // merged interval goes out first, later entries trail by one
                            wr_en       = 1'b1;
                            wr_data     = (phase_reg == PH_AFTER) ? hold_reg : merged_ent;
                            hold_next   = rd_data;
                            phase_next  = PH_AFTER;
                            wr_idx_next = wr_idx_reg + CW'(1);
                        end
                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
            end
            ST_FLUSH:
            begin
                if (ovf)
                begin
                    res_start_next = 32'sd0;
                    res_end_next   = 32'sd0;
                    res_valid_next = 1'b0;
                    res_ovf_next   = 1'b1;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_data        = (phase_reg == PH_AFTER) ? hold_reg : merged_ent;
                    count_next     = wr_idx_reg + CW'(1);
                    bank_next      = ~bank_reg;
                    res_start_next = m_start_reg;
                    res_end_next   = m_end_reg;
                    res_valid_next = 1'b1;
                    res_ovf_next   = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_start_next = res_start_reg;
                    out_end_next   = res_end_reg;
                    out_count_next = 7'(count_reg);
                    out_entry_next = res_valid_reg;
                    out_ovf_next   = res_ovf_reg;
                    out_vld_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bank_reg      <= 1'b0;
            count_reg     <= '0;
            scan_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            wr_idx_reg    <= '0;
            phase_reg     <= PH_BEFORE;
            key_a_reg     <= '0;
            key_b_reg     <= '0;
            m_start_reg   <= '0;
            m_end_reg     <= '0;
            merged_reg    <= 1'b0;
            hold_reg      <= '0;
            idx_ok_reg    <= 1'b0;
            res_start_reg <= '0;
            res_end_reg   <= '0;
            res_valid_reg <= 1'b0;
            res_ovf_reg   <= 1'b0;
            out_start_reg <= '0;
            out_end_reg   <= '0;
            out_count_reg <= '0;
            out_entry_reg <= 1'b0;
            out_ovf_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            rd_vld_reg    <= rd_vld_next;
            wr_idx_reg    <= wr_idx_next;
            phase_reg     <= phase_next;
            key_a_reg     <= key_a_next;
            key_b_reg     <= key_b_next;
            m_start_reg   <= m_start_next;
            m_end_reg     <= m_end_next;
            merged_reg    <= merged_next;
            hold_reg      <= hold_next;
            idx_ok_reg    <= idx_ok_next;
            res_start_reg <= res_start_next;
            res_end_reg   <= res_end_next;
            res_valid_reg <= res_valid_next;
            res_ovf_reg   <= res_ovf_next;
            out_start_reg <= out_start_next;
            out_end_reg   <= out_end_next;
            out_count_reg <= out_count_next;
            out_entry_reg <= out_entry_next;
            out_ovf_reg   <= out_ovf_next;
            out_vld_reg   <= out_vld_next;
        end
    end

endmodule

// File: dv/interval_union_insert_checker.sv
`timescale 1ns / 100ps
// interval_union_insert_checker: watches the request and result channels, keeps its own
// interval table, predicts every result and compares it field by field
// depends on iui_pkg, iui_req_if and iui_rsp_if
module interval_union_insert_checker import iui_pkg::*; #(
    parameter int MAX_INTERVALS = 64
) (
    input  logic clk,
    input  logic rst_n,
    iui_req_if   req,
    iui_rsp_if   rsp,
    output int   fail_count,
    output int   outstanding
);

    typedef struct packed {
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [6:0]         count;
        logic               valid;
        logic               ovf;
    } outcome_t;

    logic signed [31:0] lo_tab [MAX_INTERVALS];
    logic signed [31:0] hi_tab [MAX_INTERVALS];
    int unsigned        held_count;
    outcome_t           queued_outcomes [$];
    outcome_t           want;
    outcome_t           fresh;

    function automatic outcome_t predict_interval_op(logic func, logic signed [31:0] bound_a,
            logic signed [31:0] bound_b, logic [5:0] read_index);
        outcome_t           o;
        logic signed [31:0] a, b, t;
        logic signed [31:0] lo_next [MAX_INTERVALS];
        logic signed [31:0] hi_next [MAX_INTERVALS];
        int unsigned        first_hit, past_hit, merged, k;
        o = '0;
        if (func == FUNC_INSERT)
        begin
            a = bound_a;
            b = bound_b;
            if (a > b)
            begin
                t = a;
                a = b;
                b = t;
            end
            first_hit = 0;
            while (first_hit < held_count && hi_tab[first_hit] < a)
                first_hit++;
            past_hit = first_hit;
            while (past_hit < held_count && lo_tab[past_hit] <= b)
                past_hit++;
            merged = past_hit - first_hit;
            if (merged == 0 && held_count >= MAX_INTERVALS)
                o.ovf = 1'b1;
            else
            begin
                if (merged > 0)
                begin
                    if (lo_tab[first_hit] < a)
                        a = lo_tab[first_hit];
                    if (hi_tab[past_hit - 1] > b)
                        b = hi_tab[past_hit - 1];
                end
                lo_next = lo_tab;
                hi_next = hi_tab;
                for (k = past_hit; k < held_count; k++)
                begin
                    lo_next[first_hit + 1 + k - past_hit] = lo_tab[k];
                    hi_next[first_hit + 1 + k - past_hit] = hi_tab[k];
                end
                lo_next[first_hit] = a;
                hi_next[first_hit] = b;
                lo_tab = lo_next;
                hi_tab = hi_next;
                held_count = held_count - merged + 1;
                o.lo = a;
                o.hi = b;
                o.valid = 1'b1;
            end
        end
        else if (read_index < held_count)
        begin
            o.lo = lo_tab[read_index];
            o.hi = hi_tab[read_index];
            o.valid = 1'b1;
        end
        o.count = held_count[6:0];
        return o;
    endfunction

    task automatic check_field(string name, logic signed [63:0] exp_val,
            logic signed [63:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            queued_outcomes.delete();
            outstanding = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (queued_outcomes.size() == 0)
                begin
                    $error("result with no request waiting: start %0d end %0d",
                           rsp.result_start, rsp.result_end);
                    fail_count++;
                end
                else
                begin
                    want = queued_outcomes.pop_front();
                    check_field("result_start", 64'(want.lo), 64'(rsp.result_start));
                    check_field("result_end", 64'(want.hi), 64'(rsp.result_end));
                    check_field("stored_count", 64'(want.count), 64'(rsp.stored_count));
                    check_field("entry_valid", 64'(want.valid), 64'(rsp.entry_valid));
                    check_field("overflow", 64'(want.ovf), 64'(rsp.overflow));
                end
            end
            if (req.valid && req.ready)
            begin
                fresh = predict_interval_op(req.func, req.bound_a, req.bound_b,
                                            req.read_index);
                queued_outcomes = {queued_outcomes, fresh};
            end
            outstanding = queued_outcomes.size();
        end
    end

endmodule

// File: dv/interval_union_insert_tb.sv
`timescale 1ns / 100ps
// interval_union_insert_tb: drives directed and random insert and read requests with
// random gaps and stalls; the checker does the prediction and the verdict is given here
// depends on iui_pkg, the channel interfaces, interval_union_insert and its checker
module interval_union_insert_tb import iui_pkg::*;;

    localparam int                 TABLE_DEPTH = 64;
    localparam int                 ITEM_TARGET = 1850;
    localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX     = 32'sh7fff_ffff;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   outstanding;
    int   sent      = 0;
    bit   gaps_on   = 1'b1;
    bit   stalls_on = 1'b1;

    iui_req_if req ();
    iui_rsp_if rsp ();

    interval_union_insert #(
        .MAX_INTERVALS(TABLE_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    interval_union_insert_checker #(
        .MAX_INTERVALS(TABLE_DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("interval_union_insert_tb NOT OK");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > longint'(S32_MAX))
            return S32_MAX;
        if (v < longint'(S32_MIN))
            return S32_MIN;
        return v[31:0];
    endfunction

    task automatic send(logic func, logic signed [31:0] a, logic signed [31:0] b,
            logic [5:0] idx);
        int gap;
        @(negedge clk);
        req.valid      <= 1'b1;
        req.func       <= func;
        req.bound_a    <= a;
        req.bound_b    <= b;
        req.read_index <= idx;
        do
            @(posedge clk);
        while (!req.ready);
        sent++;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic insert_either(logic signed [31:0] a, logic signed [31:0] b);
        if ($urandom_range(0, 1))
            send(FUNC_INSERT, b, a, 6'($urandom_range(0, 63)));
        else
            send(FUNC_INSERT, a, b, 6'($urandom_range(0, 63)));
    endtask

    task automatic read_at(logic [5:0] idx);
        send(FUNC_READ, $urandom(), $urandom(), idx);
    endtask

    // hold the request side until every result is back
    task automatic drain();
        @(negedge clk);
        req.valid <= 1'b0;
        wait (outstanding == 0);
    endtask

    // result side: ready runs broken by stalls
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            rsp.ready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge clk);
            stall = stalls_on ? pick_gap() : 0;
            if (stall > 0)
            begin
                @(negedge clk);
                rsp.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        int                 mode, k, n;
        int unsigned        span, stride;
        bit                 first_round;
        logic signed [31:0] base, a;
        req.valid      = 1'b0;
        req.func       = FUNC_INSERT;
        req.bound_a    = '0;
        req.bound_b    = '0;
        req.read_index = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table, reversed ends, touching, swallowing, extremes
        read_at(6'd0);
        read_at(6'd63);
        send(FUNC_INSERT, 10, 20, 6'd0);
        send(FUNC_INSERT, 40, 30, 6'd0);
        send(FUNC_INSERT, 20, 25, 6'd0);
        send(FUNC_INSERT, 5, 10, 6'd0);
        send(FUNC_INSERT, 26, 29, 6'd0);
        send(FUNC_INSERT, 100, 0, 6'd0);
        send(FUNC_INSERT, S32_MIN, S32_MIN, 6'd0);
        send(FUNC_INSERT, S32_MAX, S32_MAX - 7, 6'd0);
        send(FUNC_INSERT, -50, -1, 6'd0);
        send(FUNC_INSERT, -1, 0, 6'd0);
        send(FUNC_INSERT, S32_MIN, S32_MIN, 6'd0);
        send(FUNC_INSERT, S32_MAX, S32_MAX, 6'd0);
        for (k = 0; k < 5; k++)
            read_at(6'(k));
        drain();

        first_round = 1'b1;
        while (sent < ITEM_TARGET)
        begin
            gaps_on   = ($urandom_range(0, 5) != 0);
            stalls_on = ($urandom_range(0, 5) != 0);
            mode = first_round ? 5 : $urandom_range(0, 9);
            first_round = 1'b0;
            n = $urandom_range(10, 40);
            case (mode)
                0, 1, 2:
                begin
                    // dense window, lots of merging
                    base = $urandom();
                    span = $urandom_range(16, 4096);
                    for (k = 0; k < n; k++)
                        if ($urandom_range(0, 3) == 0)
                            read_at(6'($urandom_range(0, 63)));
                        else
                        begin
                            a = sat32(longint'(base) + longint'($urandom_range(0, span)));
                            insert_either(a, sat32(longint'(a) +
                                                   longint'($urandom_range(0, span / 8))));
                        end
                end
                3, 4, 9:
                begin
                    // narrow intervals scattered over the whole range
                    for (k = 0; k < n; k++)
                        if ($urandom_range(0, 4) == 0)
                            read_at(6'($urandom_range(0, 63)));
                        else
                        begin
                            a = $urandom();
                            insert_either(a, (mode == 9) ? a :
                                sat32(longint'(a) + longint'($urandom_range(0, 255))));
                        end
                end
                5:
                begin
                    // fill the table, push past capacity, then read it all back
                    base = $urandom();
                    stride = $urandom_range(3, 1000);
                    for (k = 0; k < 70; k++)
                    begin
                        a = sat32(longint'(base) + longint'(k * stride));
                        insert_either(a, sat32(longint'(a) +
                                               longint'($urandom_range(0, stride - 2))));
                    end
                    for (k = 0; k < 4; k++)
                        insert_either(sat32(longint'(base) - 5000 - k * 10),
                                      sat32(longint'(base) - 4998 - k * 10));
                    for (k = 0; k < 64; k++)
                        read_at(6'(k));
                end
                6, 7:
                begin
                    if ($urandom_range(0, 2) == 0)
                        for (k = 0; k < 64; k++)
                            read_at(6'(k));
                    else
                        for (k = 0; k < n; k++)
                            read_at(6'($urandom_range(0, 63)));
                end
                default:
                begin
                    // wide inserts that swallow several entries
                    for (k = 0; k < $urandom_range(1, 3); k++)
                    begin
                        a = $urandom();
                        insert_either(a, sat32(longint'(a) +
                                               (longint'(1) << $urandom_range(4, 30))));
                        read_at(6'($urandom_range(0, 63)));
                    end
                end
            endcase
            if ($urandom_range(0, 7) == 0)
                drain();
        end

        @(negedge clk);
        req.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("interval_union_insert_tb OK");
        else
            $display("interval_union_insert_tb NOT OK");
        $finish;
    end

endmodule
